FILE: hdl/pat_pkg.sv
// shared types, constants and helper functions of the peer address table
`default_nettype none

package pat_pkg;

    // table geometry
    localparam int MAX_ENTRIES = 1024;
    localparam int HASH_SLOTS  = 2048;
    localparam int ADDR_BYTES  = 32;

    localparam int ENT_W  = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = ENT_W + 1;
    localparam int SLOT_W = $clog2(HASH_SLOTS);
    localparam int PRB_W  = SLOT_W + 1;
    localparam int ADDR_W = ADDR_BYTES * 8;
    localparam int LEN_W  = 6;

    // hash and policy constants
    localparam logic [63:0] FNV_BASIS       = 64'hCBF29CE484222325;
    localparam logic [63:0] FNV_PRIME       = 64'h00000100000001B3;
    localparam logic [31:0] STALE_AGE       = 32'd1209600;
    localparam logic [10:0] DEFAULT_SRC_CAP = 11'd64;

    // request kinds
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_MARK = 1'b1;

    typedef struct packed {
        logic [15:0]       port;
        logic [LEN_W-1:0]  len;
        logic [7:0]        net;
        logic [ADDR_W-1:0] addr;
    } pat_key_t;

    typedef struct packed {
        logic        tried;
        logic [31:0] source;
        logic [31:0] seen;
        logic [63:0] services;
        pat_key_t    key;
    } pat_entry_t;

    typedef enum logic [2:0] {
        ST_INVALID,
        ST_REFRESHED,
        ST_SRC_CAPPED,
        ST_ALL_TRIED,
        ST_ADDED,
        ST_EVICTED,
        ST_NOT_FOUND,
        ST_MARKED
    } pat_status_t;

    typedef enum logic [1:0] {
        REG_WRITABLE,
        REG_SRC_CAP,
        REG_CAPACITY
    } pat_reg_t;

    // address length each network code requires, zero for unknown codes
    function automatic logic [LEN_W-1:0] expected_len(input logic [7:0] net);
        logic [LEN_W-1:0] r;
        unique case (net)
            8'd1:    r = LEN_W'(4);
            8'd2:    r = LEN_W'(16);
            8'd3:    r = LEN_W'(10);
            8'd4:    r = LEN_W'(32);
            8'd5:    r = LEN_W'(32);
            8'd6:    r = LEN_W'(16);
            default: r = '0;
        endcase
        return r;
    endfunction

    // one fnv-1a round, kept modulo the slot count
    function automatic logic [SLOT_W-1:0] hash_mix(input logic [SLOT_W-1:0] h,
                                                   input logic [SLOT_W-1:0] x);
        logic [2*SLOT_W-1:0] p;
        p = (h ^ x) * FNV_PRIME[SLOT_W-1:0];
        return p[SLOT_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/pat_hash.sv
// byte-serial key hash giving the home slot of a key
`default_nettype none

module pat_hash (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire pat_pkg::pat_key_t           key,
    output logic                             done,
    output logic [pat_pkg::SLOT_W-1:0]       slot
);

    typedef enum logic [1:0] {H_IDLE, H_NET, H_BYTE, H_PORT} phase_t;

    phase_t                          phase_reg;
    logic [pat_pkg::SLOT_W-1:0]      h_reg;
    logic [pat_pkg::ADDR_W-1:0]      addr_reg;
    logic [pat_pkg::LEN_W-1:0]       len_reg;
    logic [pat_pkg::LEN_W-1:0]       cnt_reg;
    logic [7:0]                      net_reg;
    logic [15:0]                     port_reg;
    logic                            done_reg;

    // net, then each address byte, then port, one round a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= H_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (phase_reg)
                H_IDLE: begin
                    if (start) begin
                        h_reg     <= pat_pkg::FNV_BASIS[pat_pkg::SLOT_W-1:0];
                        addr_reg  <= key.addr;
                        len_reg   <= key.len;
                        net_reg   <= key.net;
                        port_reg  <= key.port;
                        cnt_reg   <= '0;
                        phase_reg <= H_NET;
                    end
                end
                H_NET: begin
                    h_reg     <= pat_pkg::hash_mix(h_reg, pat_pkg::SLOT_W'(net_reg));
                    phase_reg <= (len_reg == '0) ? H_PORT : H_BYTE;
                end
                H_BYTE: begin
                    h_reg    <= pat_pkg::hash_mix(h_reg, pat_pkg::SLOT_W'(addr_reg[7:0]));
                    addr_reg <= addr_reg >> 8;
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == pat_pkg::LEN_W'(len_reg - 1'b1)) begin
                        phase_reg <= H_PORT;
                    end
                end
                H_PORT: begin
                    h_reg     <= pat_pkg::hash_mix(h_reg, port_reg[pat_pkg::SLOT_W-1:0]);
                    done_reg  <= 1'b1;
                    phase_reg <= H_IDLE;
                end
                default: phase_reg <= H_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign slot = h_reg;

endmodule

`default_nettype wire

FILE: hdl/peer_address_table_with_eviction.sv
// top level of the peer address table: request sequencer, entry and slot memories
//
// Requests enter on the s_ stream (tuser carries the op, tdata the key and
// attributes); one result per request leaves on the m_ stream. Registers are
// written on the cfg channel, which is always ready.
// Requests are handled one at a time. Steps taken per request:
//   rejected request: straight to the result
//   lookup: hash of the key, then a slot read and an entry compare per probed slot
//   insert of a new key: lookup, plus the source and victim scan over the live
//     entries of the entry memory, plus a probe for an empty slot
//   eviction: lookup and scan, plus a clear of the whole slot memory, then
//     every live entry is rehashed and reindexed through the hash unit
// The entry memory read port sets the scan length; the hash unit sets the
// rebuild length. After reset the slot memory is cleared, during which no
// request is taken. A result waits in the output register while
// the receiver stalls; the next request is still taken and then waits for
// the output register before its result is placed.
`default_nettype none

module peer_address_table_with_eviction (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // request stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // net, addr_len, addr_w0, addr_w1, addr_w2, addr_w3, port, services,
    // seen_time, source_group, now_time
    input  wire logic [447:0] s_tdata,
    // op
    input  wire logic [0:0]   s_tuser,
    // result stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // status, entry_index, entry_total
    output logic [23:0]       m_tdata,
    // register writes
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [10:0]  cfg_data
);

    typedef enum logic [4:0] {
        S_CLEAR, S_RB_NEXT, S_RB_WAIT, S_RB_KEY, S_HASH_RB,
        S_IDLE, S_START, S_HASH, S_PROBE, S_SLOT, S_EWAIT, S_ECHK,
        S_SCAN, S_DECIDE, S_IPROBE, S_ICHK, S_RESP
    } state_t;

    localparam int ENT_W  = pat_pkg::ENT_W;
    localparam int CNT_W  = pat_pkg::CNT_W;
    localparam int SLOT_W = pat_pkg::SLOT_W;
    localparam int PRB_W  = pat_pkg::PRB_W;

    state_t                state_reg;
    // configuration
    logic                  writable_reg;
    logic [10:0]           src_cap_reg;
    logic [10:0]           capacity_reg;
    // request
    logic                  op_reg;
    logic                  kvalid_reg;
    pat_pkg::pat_key_t     key_reg;
    logic [63:0]           svc_reg;
    logic [31:0]           seen_reg;
    logic [31:0]           src_reg;
    logic [31:0]           now_reg;
    // table control
    logic [CNT_W-1:0]      live_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [SLOT_W-1:0]     home_reg;
    logic [SLOT_W-1:0]     clr_reg;
    logic [PRB_W-1:0]      k_reg;
    logic [CNT_W-1:0]      ent_addr_reg;
    logic [ENT_W-1:0]      ins_e_reg;
    logic [CNT_W-1:0]      rb_idx_reg;
    logic                  rb_mode_reg;
    logic                  resp_pend_reg;
    // scan
    logic                  svld_reg;
    logic [ENT_W-1:0]      sidx_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  best_vld_reg;
    logic                  best_stale_reg;
    logic [ENT_W-1:0]      best_idx_reg;
    logic [31:0]           best_seen_reg;
    // result
    pat_pkg::pat_status_t  status_reg;
    logic [ENT_W-1:0]      idx_reg;
    logic                  m_tvalid_reg;
    logic [23:0]           m_tdata_reg;

    // memories
    pat_pkg::pat_entry_t   entry_mem [pat_pkg::MAX_ENTRIES];
    logic [CNT_W-1:0]      probe_mem [pat_pkg::HASH_SLOTS];
    pat_pkg::pat_entry_t   entry_q;
    logic [CNT_W-1:0]      probe_q;

    // request fields
    logic [7:0]            in_net;
    logic [5:0]            in_len;
    logic [255:0]          in_addr;
    logic [255:0]          in_addr_m;
    logic                  in_accept;

    assign in_net  = s_tdata[7:0];
    assign in_len  = s_tdata[13:8];
    assign in_addr = s_tdata[269:14];
    assign in_accept = s_tvalid && s_tready;

    // bytes at or past the length do not belong to the key
    always_comb begin
        for (int b = 0; b < pat_pkg::ADDR_BYTES; b++) begin
            in_addr_m[b*8 +: 8] = (6'(b) < in_len) ? in_addr[b*8 +: 8] : 8'h00;
        end
    end

    // hash unit
    logic                  h_start;
    pat_pkg::pat_key_t     h_key;
    logic                  h_done;
    logic [SLOT_W-1:0]     h_slot;
    logic                  req_go;

    assign req_go  = writable_reg && kvalid_reg;
    assign h_start = (state_reg == S_START && req_go) || (state_reg == S_RB_KEY);
    assign h_key   = (state_reg == S_RB_KEY) ? entry_q.key : key_reg;

    pat_hash u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (h_start),
        .key     (h_key),
        .done    (h_done),
        .slot    (h_slot)
    );

    // derived limits and scan tests
    logic [10:0]           cap_src;
    logic [CNT_W-1:0]      cap_tab;
    logic                  capped;
    logic                  full;
    logic                  key_match;
    logic                  scan_issue;
    logic                  s_stale;
    logic                  take_best;

    assign cap_src = (src_cap_reg == '0) ? pat_pkg::DEFAULT_SRC_CAP : src_cap_reg;
    assign cap_tab = (capacity_reg == '0 || capacity_reg >= 11'(pat_pkg::MAX_ENTRIES))
                     ? CNT_W'(pat_pkg::MAX_ENTRIES) : CNT_W'(capacity_reg);
    assign capped  = (src_reg != '0) && (cnt_reg >= CNT_W'(cap_src));
    assign full    = live_reg >= cap_tab;
    assign key_match  = (entry_q.key == key_reg);
    assign scan_issue = ent_addr_reg < live_reg;
    assign s_stale = ({1'b0, entry_q.seen} + {1'b0, pat_pkg::STALE_AGE}) < {1'b0, now_reg};

    always_comb begin
        take_best = 1'b0;
        if (!entry_q.tried) begin
            if (!best_vld_reg) begin
                take_best = 1'b1;
            end else if (s_stale && !best_stale_reg) begin
                take_best = 1'b1;
            end else if ((s_stale == best_stale_reg) && (entry_q.seen < best_seen_reg)) begin
                take_best = 1'b1;
            end
        end
    end

    // entry memory write port
    logic                  e_we;
    logic [ENT_W-1:0]      e_wa;
    pat_pkg::pat_entry_t   e_wd;

    always_comb begin
        e_we = 1'b0;
        e_wa = ent_addr_reg[ENT_W-1:0];
        e_wd = entry_q;
        if (state_reg == S_ECHK && key_match) begin
            e_we = 1'b1;
            if (op_reg == pat_pkg::OP_MARK) begin
                e_wd.tried = 1'b1;
            end else begin
                if (seen_reg > entry_q.seen) begin
                    e_wd.seen = seen_reg;
                end
                if (svc_reg != '0) begin
                    e_wd.services = svc_reg;
                end
            end
        end else if (state_reg == S_DECIDE && !capped && (!full || best_vld_reg)) begin
            e_we          = 1'b1;
            e_wa          = full ? best_idx_reg : live_reg[ENT_W-1:0];
            e_wd.key      = key_reg;
            e_wd.services = svc_reg;
            e_wd.seen     = seen_reg;
            e_wd.source   = src_reg;
            e_wd.tried    = 1'b0;
        end
    end

    // slot memory write port
    logic                  p_we;
    logic [SLOT_W-1:0]     p_wa;
    logic [CNT_W-1:0]      p_wd;

    always_comb begin
        p_we = 1'b0;
        p_wa = slot_reg;
        p_wd = CNT_W'(ins_e_reg) + 1'b1;
        if (state_reg == S_CLEAR) begin
            p_we = 1'b1;
            p_wa = clr_reg;
            p_wd = '0;
        end else if (state_reg == S_ICHK && probe_q == '0) begin
            p_we = 1'b1;
        end
    end

    // memories, registered read
    always_ff @(posedge aclk) begin
        if (e_we) begin
            entry_mem[e_wa] <= e_wd;
        end
        entry_q <= entry_mem[ent_addr_reg[ENT_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (p_we) begin
            probe_mem[p_wa] <= p_wd;
        end
        probe_q <= probe_mem[slot_reg];
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            writable_reg <= 1'b1;
            src_cap_reg  <= 11'd64;
            capacity_reg <= 11'd1024;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                pat_pkg::REG_WRITABLE: writable_reg <= cfg_data[0];
                pat_pkg::REG_SRC_CAP:  src_cap_reg  <= cfg_data;
                pat_pkg::REG_CAPACITY: capacity_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // request sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            live_reg      <= '0;
            rb_mode_reg   <= 1'b0;
            resp_pend_reg <= 1'b0;
            svld_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            // the result state sets the output register itself
            if (m_tready && state_reg != S_RESP) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                // slot table clear and rebuild
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == SLOT_W'(pat_pkg::HASH_SLOTS - 1)) begin
                        rb_idx_reg  <= '0;
                        rb_mode_reg <= 1'b1;
                        state_reg   <= S_RB_NEXT;
                    end
                end
                S_RB_NEXT: begin
                    if (rb_idx_reg < live_reg) begin
                        ent_addr_reg <= rb_idx_reg;
                        state_reg    <= S_RB_WAIT;
                    end else begin
                        rb_mode_reg <= 1'b0;
                        state_reg   <= resp_pend_reg ? S_RESP : S_IDLE;
                    end
                end
                S_RB_WAIT: state_reg <= S_RB_KEY;
                S_RB_KEY: begin
                    ins_e_reg <= rb_idx_reg[ENT_W-1:0];
                    state_reg <= S_HASH_RB;
                end
                S_HASH_RB: begin
                    if (h_done) begin
                        slot_reg  <= h_slot;
                        k_reg     <= '0;
                        state_reg <= S_IPROBE;
                    end
                end
                // request intake
                S_IDLE: begin
                    if (in_accept) begin
                        op_reg     <= s_tuser[0];
                        kvalid_reg <= (in_len <= 6'(pat_pkg::ADDR_BYTES)) &&
                                      (pat_pkg::expected_len(in_net) == in_len);
                        key_reg.net  <= in_net;
                        key_reg.len  <= in_len;
                        key_reg.addr <= in_addr_m;
                        key_reg.port <= s_tdata[285:270];
                        svc_reg    <= s_tdata[349:286];
                        seen_reg   <= s_tdata[381:350];
                        src_reg    <= s_tdata[413:382];
                        now_reg    <= s_tdata[445:414];
                        state_reg  <= S_START;
                    end
                end
                S_START: begin
                    idx_reg <= '0;
                    if (req_go) begin
                        state_reg <= S_HASH;
                    end else begin
                        status_reg <= (writable_reg && op_reg == pat_pkg::OP_MARK)
                                      ? pat_pkg::ST_NOT_FOUND : pat_pkg::ST_INVALID;
                        state_reg  <= S_RESP;
                    end
                end
                // lookup along the probe chain
                S_HASH: begin
                    if (h_done) begin
                        slot_reg  <= h_slot;
                        home_reg  <= h_slot;
                        k_reg     <= '0;
                        state_reg <= S_PROBE;
                    end
                end
                S_PROBE: state_reg <= S_SLOT;
                S_SLOT: begin
                    if (probe_q == '0 || probe_q > live_reg) begin
                        if (op_reg == pat_pkg::OP_MARK) begin
                            status_reg <= pat_pkg::ST_NOT_FOUND;
                            state_reg  <= S_RESP;
                        end else begin
                            ent_addr_reg <= '0;
                            svld_reg     <= 1'b0;
                            cnt_reg      <= '0;
                            best_vld_reg <= 1'b0;
                            state_reg    <= S_SCAN;
                        end
                    end else begin
                        ent_addr_reg <= probe_q - 1'b1;
                        state_reg    <= S_EWAIT;
                    end
                end
                S_EWAIT: state_reg <= S_ECHK;
                S_ECHK: begin
                    if (key_match) begin
                        idx_reg    <= ent_addr_reg[ENT_W-1:0];
                        status_reg <= (op_reg == pat_pkg::OP_MARK)
                                      ? pat_pkg::ST_MARKED : pat_pkg::ST_REFRESHED;
                        state_reg  <= S_RESP;
                    end else if (k_reg == PRB_W'(pat_pkg::HASH_SLOTS - 1)) begin
                        if (op_reg == pat_pkg::OP_MARK) begin
                            status_reg <= pat_pkg::ST_NOT_FOUND;
                            state_reg  <= S_RESP;
                        end else begin
                            ent_addr_reg <= '0;
                            svld_reg     <= 1'b0;
                            cnt_reg      <= '0;
                            best_vld_reg <= 1'b0;
                            state_reg    <= S_SCAN;
                        end
                    end else begin
                        slot_reg  <= slot_reg + 1'b1;
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_PROBE;
                    end
                end
                // source count and victim choice over live entries
                S_SCAN: begin
                    svld_reg <= scan_issue;
                    if (scan_issue) begin
                        sidx_reg     <= ent_addr_reg[ENT_W-1:0];
                        ent_addr_reg <= ent_addr_reg + 1'b1;
                    end
                    if (svld_reg) begin
                        if (src_reg != '0 && entry_q.source == src_reg) begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                        if (take_best) begin
                            best_vld_reg   <= 1'b1;
                            best_idx_reg   <= sidx_reg;
                            best_stale_reg <= s_stale;
                            best_seen_reg  <= entry_q.seen;
                        end
                    end
                    if (!scan_issue && !svld_reg) begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (capped) begin
                        status_reg <= pat_pkg::ST_SRC_CAPPED;
                        state_reg  <= S_RESP;
                    end else if (full) begin
                        if (!best_vld_reg) begin
                            status_reg <= pat_pkg::ST_ALL_TRIED;
                            state_reg  <= S_RESP;
                        end else begin
                            status_reg    <= pat_pkg::ST_EVICTED;
                            idx_reg       <= best_idx_reg;
                            clr_reg       <= '0;
                            resp_pend_reg <= 1'b1;
                            state_reg     <= S_CLEAR;
                        end
                    end else begin
                        status_reg  <= pat_pkg::ST_ADDED;
                        idx_reg     <= live_reg[ENT_W-1:0];
                        ins_e_reg   <= live_reg[ENT_W-1:0];
                        live_reg    <= live_reg + 1'b1;
                        slot_reg    <= home_reg;
                        k_reg       <= '0;
                        rb_mode_reg <= 1'b0;
                        state_reg   <= S_IPROBE;
                    end
                end
                // find an empty slot for one entry
                S_IPROBE: state_reg <= S_ICHK;
                S_ICHK: begin
                    if (probe_q == '0 || k_reg == PRB_W'(pat_pkg::HASH_SLOTS - 1)) begin
                        if (rb_mode_reg) begin
                            rb_idx_reg <= rb_idx_reg + 1'b1;
                            state_reg  <= S_RB_NEXT;
                        end else begin
                            state_reg <= S_RESP;
                        end
                    end else begin
                        slot_reg  <= slot_reg + 1'b1;
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_IPROBE;
                    end
                end
                // place the result once the output register is free
                S_RESP: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg  <= 1'b1;
                        m_tdata_reg   <= {live_reg, idx_reg, status_reg};
                        resp_pend_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

`ifndef SYNTH
    // requests are handled one at a time
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> !s_tready)
        else $error("request taken while another is in progress");

    // a new entry is always the last live one
    a_added_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tdata_reg[2:0] == pat_pkg::ST_ADDED) |->
        (CNT_W'(m_tdata_reg[12:3]) + 1'b1 == m_tdata_reg[23:13]))
        else $error("added entry index does not match entry total");

    // hash results arrive only while the sequencer waits for them
    a_hash_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        h_done |-> (state_reg == S_HASH || state_reg == S_HASH_RB))
        else $error("hash finished outside a hash wait state");

    // live count stays within the table
    a_live_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        live_reg <= CNT_W'(pat_pkg::MAX_ENTRIES))
        else $error("live count beyond table size");
`endif

endmodule

`default_nettype wire
